/* rtl/core/iqsh_pkg.sv */
// ----------------------------------------------------------------------------
// iqsh_pkg
// shared types and constants for the iq half-float scaler
// ----------------------------------------------------------------------------
package iqsh_pkg;

   localparam logic [15:0] HALF_INF   = 16'h7C00;
   localparam logic [15:0] HALF_QUIET = 16'h0200;
   localparam logic [31:0] FP32_INF   = 32'h7F800000;
   localparam logic [31:0] FP32_QNAN  = 32'h7FC00000;
   localparam logic [31:0] FP32_QBIT  = 32'h00400000;

   localparam logic [0:0] CSR_GAIN = 1'b0;

   // stage 1 to stage 2 of one lane
   typedef struct packed {
      logic        special;
      logic [31:0] special_val;
      logic        sign;
      logic [7:0]  exp;
      logic [39:0] prod;
   } mul_stage_type;

   // stage 2 to stage 3 of one lane
   typedef struct packed {
      logic        special;
      logic [31:0] special_val;
      logic        sign;
      logic [9:0]  exp;
      logic [5:0]  msb;
      logic [39:0] prod;
   } norm_stage_type;

endpackage

/* rtl/core/iqsh_lane.sv */
// ----------------------------------------------------------------------------
// iqsh_lane
// one part: int16 times fp32 gain, rne to fp32, rne to fp16, four stages
// ----------------------------------------------------------------------------
module iqsh_lane import iqsh_pkg::*; (
   input  logic        clock,
   input  logic [3:0]  adv,
   input  logic [15:0] part,
   input  logic [31:0] gain,
   output logic [15:0] half
);

   mul_stage_type  s1_ff, s1_in;
   norm_stage_type s2_ff, s2_in;
   logic [31:0]    s3_ff, s3_in;
   logic [15:0]    s4_ff, s4_in;

   // stage 1: magnitude, specials, multiply
   always_comb begin
      logic [15:0] a;
      logic        gs;
      logic [7:0]  ge;
      logic [22:0] gm;
      logic [23:0] sig;
      a  = part[15] ? (16'd0 - part) : part;
      gs = gain[31];
      ge = gain[30:23];
      gm = gain[22:0];
      sig = (ge != 8'd0) ? {1'b1, gm} : {1'b0, gm};
      s1_in.sign = part[15] ^ gs;
      s1_in.exp  = (ge != 8'd0) ? ge : 8'd1;
      s1_in.prod = {24'd0, a} * {16'd0, sig};
      s1_in.special = 1'b0;
      s1_in.special_val = {s1_in.sign, 31'd0};
      if (ge == 8'hFF) begin
         s1_in.special = 1'b1;
         if (gm != 23'd0)      s1_in.special_val = gain | FP32_QBIT;
         else if (a == 16'd0)  s1_in.special_val = FP32_QNAN;
         else                  s1_in.special_val = {s1_in.sign, 31'd0} | FP32_INF;
      end else if (a == 16'd0 || gain[30:0] == 31'd0) begin
         s1_in.special = 1'b1;
      end
   end

   // stage 2: leading one position
   always_comb begin
      logic [5:0] m;
      m = 6'd0;
      for (int i = 0; i < 40; i++) begin
         if (s1_ff.prod[i]) m = 6'(i);
      end
      s2_in.special     = s1_ff.special;
      s2_in.special_val = s1_ff.special_val;
      s2_in.sign        = s1_ff.sign;
      s2_in.exp         = {2'd0, s1_ff.exp};
      s2_in.msb         = m;
      s2_in.prod        = s1_ff.prod;
   end

   // stage 3: round to fp32
   always_comb begin
      logic [9:0]  sum;
      logic [9:0]  be;
      logic [5:0]  r;
      logic [39:0] sh;
      logic [39:0] rem;
      logic [39:0] hlf;
      logic [24:0] mant;
      sum = s2_ff.exp + {4'd0, s2_ff.msb};
      be  = sum - 10'd23;
      r   = s2_ff.msb - 6'd23;
      mant = 25'd0;
      rem  = 40'd0;
      hlf  = 40'd0;
      sh   = 40'd0;
      if (s2_ff.special) begin
         s3_in = s2_ff.special_val;
      end else if (sum < 10'd24) begin
         sh = s2_ff.prod << (s2_ff.exp - 10'd1);
         s3_in = {s2_ff.sign, sh[30:0]};
      end else begin
         if (s2_ff.msb > 6'd23) begin
            sh   = s2_ff.prod >> r;
            rem  = s2_ff.prod & ((40'd1 << r) - 40'd1);
            hlf  = 40'd1 << (r - 6'd1);
            mant = sh[24:0];
            if (rem > hlf || (rem == hlf && mant[0])) mant = mant + 25'd1;
         end else begin
            sh   = s2_ff.prod << (6'd23 - s2_ff.msb);
            mant = sh[24:0];
         end
         if (mant[24]) begin
            mant = mant >> 1;
            be   = be + 10'd1;
         end
         if (be >= 10'd255) s3_in = {s2_ff.sign, 31'd0} | FP32_INF;
         else s3_in = {s2_ff.sign, be[7:0], mant[22:0]};
      end
   end

   // stage 4: fp32 to fp16
   always_comb begin
      logic [15:0] sg;
      logic [7:0]  e8;
      logic [22:0] m;
      logic [23:0] full;
      logic [4:0]  shn;
      logic [23:0] q;
      logic [23:0] rem;
      logic [23:0] hlf;
      logic [10:0] m16;
      logic [12:0] low;
      logic [4:0]  e16;
      sg   = {s3_ff[31], 15'd0};
      e8   = s3_ff[30:23];
      m    = s3_ff[22:0];
      full = {1'b1, m};
      shn  = 5'd0;
      q    = 24'd0;
      rem  = 24'd0;
      hlf  = 24'd0;
      low  = m[12:0];
      m16  = {1'b0, m[22:13]};
      e16  = 5'(e8 - 8'd112);
      if (e8 == 8'hFF) begin
         s4_in = sg | HALF_INF | ((m != 23'd0) ? ({6'd0, m[22:13]} | HALF_QUIET) : 16'd0);
      end else if (e8 >= 8'd143) begin
         s4_in = sg | HALF_INF;
      end else if (e8 <= 8'd112) begin
         if (e8 < 8'd102) begin
            s4_in = sg;
         end else begin
            shn = 5'(8'd126 - e8);
            q   = full >> shn;
            rem = full & ((24'd1 << shn) - 24'd1);
            hlf = 24'd1 << (shn - 5'd1);
            if (rem > hlf || (rem == hlf && q[0])) q = q + 24'd1;
            s4_in = sg | q[15:0];
         end
      end else begin
         if (low > 13'h1000 || (low == 13'h1000 && m16[0])) m16 = m16 + 11'd1;
         if (m16[10]) s4_in = sg | {1'b0, e16 + 5'd1, 10'd0};
         else s4_in = sg | {1'b0, e16, m16[9:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) s1_ff <= s1_in;
      if (adv[1]) s2_ff <= s2_in;
      if (adv[2]) s3_ff <= s3_in;
      if (adv[3]) s4_ff <= s4_in;
   end

   assign half = s4_ff;

endmodule

/* rtl/core/iq_scale_to_half_float.sv */
// ----------------------------------------------------------------------------
// iq_scale_to_half_float
// scales a complex int16 sample by an fp32 gain and emits two fp16 halves
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  req     | req_valid/ready, in_phase, quadrature   | in
//  rsp     | rsp_valid/ready, *_half, span_end_out   | out
//  csr     | apb write/read, gain_bits at 0x0        | in
//
//  one transaction per cycle when the output is not stalled, through the registered lane stages
//  two lanes (i and q) share a valid/stall pipeline and merge at the output
//  a stall holds every valid stage; the pipe still fills into empty stages
//  synchronous reset clears valids and sets the gain to 1.0
// ----------------------------------------------------------------------------
module iq_scale_to_half_float import iqsh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_in_phase,
   input  logic [15:0] req_quadrature,
   input  logic        req_span_end_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_in_phase_half,
   output logic [15:0] rsp_quadrature_half,
   output logic        rsp_span_end_out,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [31:0] gain_ff, gain_in;
   logic [3:0]  vld_ff, vld_in;
   logic [3:0]  end_ff, end_in;
   logic [3:0]  adv;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[1:1] == CSR_GAIN) ? gain_ff : 32'd0;

   always_comb begin
      gain_in = gain_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1:1] == CSR_GAIN)
         gain_in = csr_pwdata;
   end

   always_comb begin
      adv[3] = !vld_ff[3] || rsp_ready;
      adv[2] = !vld_ff[2] || adv[3];
      adv[1] = !vld_ff[1] || adv[2];
      adv[0] = !vld_ff[0] || adv[1];
      vld_in = vld_ff;
      end_in = end_ff;
      if (adv[0]) begin
         vld_in[0] = req_valid;
         end_in[0] = req_span_end_in;
      end
      for (int i = 1; i < 4; i++) begin
         if (adv[i]) begin
            vld_in[i] = vld_ff[i-1];
            end_in[i] = end_ff[i-1];
         end
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = vld_ff[3];
   assign rsp_span_end_out = end_ff[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= 32'h3F800000;
         vld_ff  <= 4'd0;
      end else begin
         gain_ff <= gain_in;
         vld_ff  <= vld_in;
      end
      end_ff <= end_in;
   end

   iqsh_lane u_lane_i (
      .clock (clock),
      .adv   (adv),
      .part  (req_in_phase),
      .gain  (gain_ff),
      .half  (rsp_in_phase_half)
   );

   iqsh_lane u_lane_q (
      .clock (clock),
      .adv   (adv),
      .part  (req_quadrature),
      .gain  (gain_ff),
      .half  (rsp_quadrature_half)
   );

endmodule
